// ===== src/xcfr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the xor-checked frame receiver: payload structs, status codes,
// register indexes and parser phases. No dependencies.
package xcfr_pkg;

   localparam int SIGN_BYTES = 4;
   localparam int SIGN_IDX_W = (SIGN_BYTES > 1) ? $clog2(SIGN_BYTES) : 1;
   localparam logic [SIGN_IDX_W-1:0] SIGN_LAST = SIGN_IDX_W'(SIGN_BYTES - 1);

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 8'd3;

   // register reset values
   localparam logic [7:0] START_BYTE_RST    = 8'd92;
   localparam logic [7:0] END_BYTE_RST      = 8'd202;
   localparam logic [7:0] MAX_LENGTH_RST    = 8'd236;
   localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd5;

   // input item kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // frame status codes
   localparam logic [2:0] ST_ACCEPTED   = 3'd0;
   localparam logic [2:0] ST_QUEUE_FULL = 3'd1;
   localparam logic [2:0] ST_CHECK_BAD  = 3'd2;
   localparam logic [2:0] ST_END_BAD    = 3'd3;
   localparam logic [2:0] ST_TOO_LONG   = 3'd4;
   localparam logic [2:0] ST_TIMEOUT    = 3'd5;

   typedef enum logic [6:0] {
      PH_HUNT = 7'b0000001,
      PH_TYPE = 7'b0000010,
      PH_SIGN = 7'b0000100,
      PH_LEN  = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_XOR  = 7'b0100000,
      PH_END  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
      logic       queue_full;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [2:0]  status;
      logic [7:0]  frame_type;
      logic [31:0] frame_sign;
      logic [7:0]  frame_length;
   } rsp_payload_type;

endpackage

// ===== src/xor_checked_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// Xor-checked frame receiver: phase machine, running XOR, output register and skid.
// Depends on xcfr_pkg.

// Takes one byte or timer tick per cycle while req_stall is low and gives at most
// one result per item: each payload byte as it arrives, and one status per frame
// (accepted, queue full, checksum bad, end bad, too long, timeout). The whole parse
// step is a single pass of logic between the request and the result register, so a
// new item is accepted every cycle while the skid is empty; a one-entry skid stage
// behind the result register keeps input flowing while the result side stalls
// until it fills, after which req_stall rises until the skid drains. Configuration
// writes take effect on the next cycle and belong to idle time.
module xor_checked_frame_receiver_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  xcfr_pkg::req_payload_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output xcfr_pkg::rsp_payload_type          rsp_data,
   input  logic                               csr_wr_en,
   input  logic [xcfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [xcfr_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import xcfr_pkg::*;

   // configuration
   logic [7:0] start_byte_ff, end_byte_ff, max_length_ff, timeout_ticks_ff;

   // parser state
   phase_type               phase_ff, phase_in;
   logic [SIGN_IDX_W-1:0]   sign_count_ff, sign_count_in;
   logic [7:0]              payload_count_ff, payload_count_in;
   logic [7:0]              held_length_ff, held_length_in;
   logic [7:0]              held_type_ff, held_type_in;
   logic [31:0]             held_sign_ff, held_sign_in;
   logic [7:0]              running_xor_ff, running_xor_in;
   logic [7:0]              received_check_ff, received_check_in;
   logic [7:0]              idle_ticks_ff, idle_ticks_in;

   // result path
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_data_ff, skid_data_in;

   logic            accept;
   logic            new_valid;
   rsp_payload_type new_data;
   logic            out_free;
   logic [7:0]      idle_inc;
   logic [7:0]      count_inc;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign idle_inc  = (idle_ticks_ff == 8'hFF) ? idle_ticks_ff : idle_ticks_ff + 8'd1;
   assign count_inc = payload_count_ff + 8'd1;

   // parse step
   always_comb begin
      phase_in          = phase_ff;
      sign_count_in     = sign_count_ff;
      payload_count_in  = payload_count_ff;
      held_length_in    = held_length_ff;
      held_type_in      = held_type_ff;
      held_sign_in      = held_sign_ff;
      running_xor_in    = running_xor_ff;
      received_check_in = received_check_ff;
      idle_ticks_in     = idle_ticks_ff;
      new_valid         = 1'b0;
      new_data          = '0;
      new_data.kind         = KIND_STATUS;
      new_data.frame_type   = held_type_ff;
      new_data.frame_sign   = held_sign_ff;
      new_data.frame_length = held_length_ff;

      if (req_data.cmd == CMD_TICK) begin
         if (phase_ff != PH_HUNT) begin
            idle_ticks_in = idle_inc;
            if (idle_inc > timeout_ticks_ff) begin
               new_valid       = 1'b1;
               new_data.status = ST_TIMEOUT;
               phase_in        = PH_HUNT;
            end
         end
      end else begin
         idle_ticks_in = 8'd0;
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_data.rx_byte == start_byte_ff) begin
                  phase_in          = PH_TYPE;
                  held_type_in      = 8'd0;
                  held_sign_in      = 32'd0;
                  held_length_in    = 8'd0;
                  received_check_in = 8'd0;
                  running_xor_in    = 8'd0;
                  sign_count_in     = '0;
                  payload_count_in  = 8'd0;
               end
            end
            PH_TYPE: begin
               held_type_in   = req_data.rx_byte;
               running_xor_in = running_xor_ff ^ req_data.rx_byte;
               sign_count_in  = '0;
               phase_in       = PH_SIGN;
            end
            PH_SIGN: begin
               held_sign_in[8*sign_count_ff +: 8] = req_data.rx_byte;
               running_xor_in = running_xor_ff ^ req_data.rx_byte;
               sign_count_in  = sign_count_ff + SIGN_IDX_W'(1);
               if (sign_count_ff == SIGN_LAST) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               held_length_in   = req_data.rx_byte;
               running_xor_in   = running_xor_ff ^ req_data.rx_byte;
               payload_count_in = 8'd0;
               if (req_data.rx_byte > max_length_ff) begin
                  new_valid             = 1'b1;
                  new_data.status       = ST_TOO_LONG;
                  new_data.frame_length = req_data.rx_byte;
                  phase_in              = PH_HUNT;
               end else if (req_data.rx_byte != 8'd0) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_XOR;
               end
            end
            PH_DATA: begin
               new_valid      = 1'b1;
               new_data       = '0;
               new_data.kind          = KIND_PAYLOAD;
               new_data.payload_byte  = req_data.rx_byte;
               new_data.payload_index = payload_count_ff;
               running_xor_in   = running_xor_ff ^ req_data.rx_byte;
               payload_count_in = count_inc;
               if (count_inc == held_length_ff) begin
                  phase_in = PH_XOR;
               end
            end
            PH_XOR: begin
               received_check_in = req_data.rx_byte;
               phase_in          = PH_END;
            end
            PH_END: begin
               new_valid = 1'b1;
               phase_in  = PH_HUNT;
               priority if (req_data.rx_byte != end_byte_ff) begin
                  new_data.status = ST_END_BAD;
               end else if (received_check_ff != running_xor_ff) begin
                  new_data.status = ST_CHECK_BAD;
               end else if (req_data.queue_full) begin
                  new_data.status = ST_QUEUE_FULL;
               end else begin
                  new_data.status = ST_ACCEPTED;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // output register with one-entry skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_in = accept && new_valid;
         rsp_data_in  = new_data;
      end else if (accept && new_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff     <= START_BYTE_RST;
         end_byte_ff       <= END_BYTE_RST;
         max_length_ff     <= MAX_LENGTH_RST;
         timeout_ticks_ff  <= TIMEOUT_TICKS_RST;
         phase_ff          <= PH_HUNT;
         sign_count_ff     <= '0;
         payload_count_ff  <= 8'd0;
         held_length_ff    <= 8'd0;
         held_type_ff      <= 8'd0;
         held_sign_ff      <= 32'd0;
         running_xor_ff    <= 8'd0;
         received_check_ff <= 8'd0;
         idle_ticks_ff     <= 8'd0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_START_BYTE:    start_byte_ff    <= csr_wr_data;
               CSR_END_BYTE:      end_byte_ff      <= csr_wr_data;
               CSR_MAX_LENGTH:    max_length_ff    <= csr_wr_data;
               CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff          <= phase_in;
            sign_count_ff     <= sign_count_in;
            payload_count_ff  <= payload_count_in;
            held_length_ff    <= held_length_in;
            held_type_ff      <= held_type_in;
            held_sign_ff      <= held_sign_in;
            running_xor_ff    <= running_xor_in;
            received_check_ff <= received_check_in;
            idle_ticks_ff     <= idle_ticks_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result data, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
